@@ hw/rtl/png_time_chunk_scanner_defines.svh @@
// ----------------------------------------------------------------------------
// PNG tIME chunk scanner assertion macros
// Clocked implication checks shared by the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef PNG_TIME_CHUNK_SCANNER_DEFINES_SVH
`define PNG_TIME_CHUNK_SCANNER_DEFINES_SVH

// same-cycle implication
`define TCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("png_time_chunk_scanner check failed");

// next-cycle implication
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("png_time_chunk_scanner check failed");

`endif

@@ hw/rtl/png_tcs_pkg.sv @@
// ----------------------------------------------------------------------------
// PNG tIME chunk scanner package
// Shared types, codes and constants of the scanner.
// ----------------------------------------------------------------------------
package png_tcs_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic REG_MIN_YEAR = 1'b0;
    localparam logic REG_MAX_YEAR = 1'b1;

    localparam logic [15:0] MIN_YEAR_RESET = 16'd1970;
    localparam logic [15:0] MAX_YEAR_RESET = 16'd2100;

    localparam logic [1:0] STATUS_BAD_SIG = 2'd0;
    localparam logic [1:0] STATUS_NO_TIME = 2'd1;
    localparam logic [1:0] STATUS_FOUND   = 2'd2;

    localparam logic [31:0] TYPE_TIME = 32'h74494D45;
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;
    localparam logic [31:0] TIME_LENGTH = 32'd7;

    localparam logic [7:0] MONTH_MAX  = 8'd12;
    localparam logic [7:0] DAY_MAX    = 8'd31;
    localparam logic [7:0] HOUR_MAX   = 8'd23;
    localparam logic [7:0] MINUTE_MAX = 8'd59;
    localparam logic [7:0] SECOND_MAX = 8'd60;

    typedef enum logic [5:0] {
        PH_SIG  = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_TYPE = 6'b000100,
        PH_DATA = 6'b001000,
        PH_CRC  = 6'b010000,
        PH_DONE = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } tcs_result_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'h89;
            3'd1: b = 8'h50;
            3'd2: b = 8'h4E;
            3'd3: b = 8'h47;
            3'd4: b = 8'h0D;
            3'd5: b = 8'h0A;
            3'd6: b = 8'h1A;
            3'd7: b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/png_tcs_cfg.sv @@
// ----------------------------------------------------------------------------
// PNG tIME chunk scanner configuration registers
// APB-style write and read of the accepted year window.
// ----------------------------------------------------------------------------
module png_tcs_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [png_tcs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [png_tcs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [png_tcs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    output logic [15:0]                        min_year,
    output logic [15:0]                        max_year
);
    import png_tcs_pkg::*;

    logic [15:0] min_year_reg;
    logic [15:0] max_year_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= MIN_YEAR_RESET;
            max_year_reg <= MAX_YEAR_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_MIN_YEAR: min_year_reg <= pwdata[15:0];
                REG_MAX_YEAR: max_year_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MIN_YEAR: prdata = {{(CFG_DATA_W-16){1'b0}}, min_year_reg};
            REG_MAX_YEAR: prdata = {{(CFG_DATA_W-16){1'b0}}, max_year_reg};
            default:      prdata = '0;
        endcase
    end

    assign min_year = min_year_reg;
    assign max_year = max_year_reg;

endmodule

@@ hw/rtl/png_tcs_walker.sv @@
// ----------------------------------------------------------------------------
// PNG tIME chunk scanner chunk walker
// Signature check, chunk walk, tIME capture and result formation.
// ----------------------------------------------------------------------------
module png_tcs_walker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    input  logic [15:0]              min_year,
    input  logic [15:0]              max_year,
    output png_tcs_pkg::tcs_result_t result
);
    import png_tcs_pkg::*;

    phase_t      phase_reg,    phase_next,    phase_take;
    logic [31:0] count_reg,    count_next,    count_take;
    logic [31:0] length_reg,   length_next,   length_take;
    logic [31:0] ctype_reg,    ctype_next,    ctype_take;
    logic [55:0] capture_reg,  capture_next,  capture_take;
    logic [55:0] kept_reg,     kept_next,     kept_take;
    logic        found_reg,    found_next,    found_take;
    logic        sig_ok_reg,   sig_ok_next,   sig_ok_take;

    logic [31:0] count_inc;
    logic [31:0] ctype_shift;
    logic        is_time;
    logic        date_ok;
    logic [55:0] date_out;

    assign count_inc   = count_reg + 32'd1;
    assign ctype_shift = {ctype_reg[23:0], data_byte};
    assign is_time     = (ctype_reg == TYPE_TIME) && (length_reg == TIME_LENGTH);

    assign date_ok = (capture_reg[55:40] >= min_year) && (capture_reg[55:40] <= max_year)
                  && (capture_reg[39:32] >= 8'd1) && (capture_reg[39:32] <= MONTH_MAX)
                  && (capture_reg[31:24] >= 8'd1) && (capture_reg[31:24] <= DAY_MAX)
                  && (capture_reg[23:16] <= HOUR_MAX)
                  && (capture_reg[15:8] <= MINUTE_MAX)
                  && (capture_reg[7:0] <= SECOND_MAX);

    always_comb
    begin
        phase_take   = phase_reg;
        count_take   = count_reg;
        length_take  = length_reg;
        ctype_take   = ctype_reg;
        capture_take = capture_reg;
        kept_take    = kept_reg;
        found_take   = found_reg;
        sig_ok_take  = sig_ok_reg;
        case (phase_reg)
            PH_SIG:
            begin
                if (data_byte != sig_byte(count_reg[2:0]))
                begin
                    phase_take = PH_DONE;
                end
                else if (count_reg[2:0] == 3'd7)
                begin
                    sig_ok_take = 1'b1;
                    count_take  = '0;
                    phase_take  = PH_LEN;
                end
                else
                begin
                    count_take = count_inc;
                end
            end
            PH_LEN:
            begin
                length_take = {length_reg[23:0], data_byte};
                count_take  = count_inc;
                if (count_reg == 32'd3)
                begin
                    count_take = '0;
                    phase_take = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                ctype_take = ctype_shift;
                count_take = count_inc;
                if (count_reg == 32'd3)
                begin
                    count_take   = '0;
                    capture_take = '0;
                    if (ctype_shift == TYPE_IEND)
                        phase_take = PH_DONE;
                    else if (length_reg == 32'd0)
                        phase_take = PH_CRC;
                    else
                        phase_take = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (is_time)
                    capture_take = {capture_reg[47:0], data_byte};
                count_take = count_inc;
                if (count_inc == length_reg)
                begin
                    count_take = '0;
                    phase_take = PH_CRC;
                end
            end
            PH_CRC:
            begin
                count_take = count_inc;
                if (count_reg == 32'd3)
                begin
                    if (is_time && date_ok)
                    begin
                        kept_take  = capture_reg;
                        found_take = 1'b1;
                    end
                    count_take  = '0;
                    length_take = '0;
                    ctype_take  = '0;
                    phase_take  = PH_LEN;
                end
            end
            default: ;
        endcase
    end

    // clear the walk after the last byte, keep the year window
    always_comb
    begin
        if (last_byte)
        begin
            phase_next   = PH_SIG;
            count_next   = '0;
            length_next  = '0;
            ctype_next   = '0;
            capture_next = '0;
            kept_next    = '0;
            found_next   = 1'b0;
            sig_ok_next  = 1'b0;
        end
        else
        begin
            phase_next   = phase_take;
            count_next   = count_take;
            length_next  = length_take;
            ctype_next   = ctype_take;
            capture_next = capture_take;
            kept_next    = kept_take;
            found_next   = found_take;
            sig_ok_next  = sig_ok_take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SIG;
            count_reg   <= '0;
            length_reg  <= '0;
            ctype_reg   <= '0;
            capture_reg <= '0;
            kept_reg    <= '0;
            found_reg   <= 1'b0;
            sig_ok_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            ctype_reg   <= ctype_next;
            capture_reg <= capture_next;
            kept_reg    <= kept_next;
            found_reg   <= found_next;
            sig_ok_reg  <= sig_ok_next;
        end
    end

    assign date_out = (sig_ok_take && found_take) ? kept_take : '0;

    always_comb
    begin
        if (!sig_ok_take)
            result.status = STATUS_BAD_SIG;
        else if (found_take)
            result.status = STATUS_FOUND;
        else
            result.status = STATUS_NO_TIME;
        result.year   = date_out[55:40];
        result.month  = date_out[35:32];
        result.day    = date_out[28:24];
        result.hour   = date_out[20:16];
        result.minute = date_out[13:8];
        result.second = date_out[5:0];
    end

endmodule

@@ hw/rtl/png_time_chunk_scanner.sv @@
// ----------------------------------------------------------------------------
// PNG tIME chunk scanner top level
// Path: a last byte is registered in the input stage, then its result in the output stage.
// Throughput: 1 byte per cycle, as the walker state updates on every accepted byte;
// a last byte waits while an earlier result is held on the output.
// Reset: rst_n clears walk state, empties both stages, year window 1970..2100.
// ----------------------------------------------------------------------------
`include "png_time_chunk_scanner_defines.svh"

module png_time_chunk_scanner (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [png_tcs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [png_tcs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [png_tcs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         data_byte,
    input  logic                               last_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic [15:0]                        year,
    output logic [3:0]                         month,
    output logic [4:0]                         day,
    output logic [4:0]                         hour,
    output logic [5:0]                         minute,
    output logic [5:0]                         second
);
    import png_tcs_pkg::*;

    logic [15:0] min_year;
    logic [15:0] max_year;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    tcs_result_t out_res_reg;
    tcs_result_t walk_res;
    logic        out_free;
    logic        step;
    logic        last_step;
    logic        last_held;
    logic        status_legal;
    logic        date_clear;

    png_tcs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .min_year (min_year),
        .max_year (max_year)
    );

    // a last byte waits for the result slot; other bytes always advance
    assign out_free = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && (!in_last_reg || out_free);
    assign in_ready = !in_valid_reg || step;

    png_tcs_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .min_year  (min_year),
        .max_year  (max_year),
        .result    (walk_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
            out_res_reg <= walk_res;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign year      = out_res_reg.year;
    assign month     = out_res_reg.month;
    assign day       = out_res_reg.day;
    assign hour      = out_res_reg.hour;
    assign minute    = out_res_reg.minute;
    assign second    = out_res_reg.second;

    assign last_step    = step && in_last_reg;
    assign last_held    = in_valid_reg && in_last_reg && out_valid_reg && !out_ready;
    assign status_legal = (out_res_reg.status == STATUS_BAD_SIG)
                       || (out_res_reg.status == STATUS_NO_TIME)
                       || (out_res_reg.status == STATUS_FOUND);
    assign date_clear   = (out_res_reg.year == 16'd0) && (out_res_reg.month == 4'd0)
                       && (out_res_reg.day == 5'd0);

    `TCS_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid_reg, status_legal)
    `TCS_ASSERT_IMPL(a_no_date, clk, rst_n, out_valid_reg && !(out_res_reg.status == STATUS_FOUND), date_clear)
    `TCS_ASSERT_IMPL(a_last_stall, clk, rst_n, last_held, !in_ready && !step)
    `TCS_ASSERT_NEXT(a_last_result, clk, rst_n, last_step, out_valid_reg)
    `TCS_ASSERT_IMPL(a_result_source, clk, rst_n, $rose(out_valid_reg), $past(last_step))

endmodule

@@ tb/sv/tb_png_time_chunk_scanner.sv @@
// ----------------------------------------------------------------------------
// PNG tIME chunk scanner testbench
// Feeds byte streams shaped like PNG files, mostly well formed with random
// chunks and dates, plus broken signatures, noise and truncated files. A
// built-in scanner model predicts the report for each final byte, and the
// reports are checked field by field as they leave the block. The year window
// is reprogrammed over the APB port between runs.
// ----------------------------------------------------------------------------
module tb_png_time_chunk_scanner;

    import png_tcs_pkg::*;

    localparam int          SETTLE_CYCLES   = 8;
    localparam int          WINDOW_COUNT    = 7;
    localparam int          BYTES_PER_WIN   = 205;
    localparam int          FILES_PER_WIN   = 4;
    localparam logic [63:0] PNG_MAGIC       = 64'h89504E470D0A1A0A;

    localparam logic [CFG_ADDR_W-1:0] MIN_YEAR_ADDR = {REG_MIN_YEAR, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] MAX_YEAR_ADDR = {REG_MAX_YEAR, 2'b00};

    localparam tcs_result_t NO_REPORT     = '0;
    localparam tcs_result_t NO_SIGNATURE  = {STATUS_BAD_SIG, 42'd0};
    localparam tcs_result_t NO_TIME_FOUND = {STATUS_NO_TIME, 42'd0};

    typedef struct packed {
        logic [7:0]  b;
        logic        lst;
        logic        fixed;
        tcs_result_t want;
    } probe_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            data_byte;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic [15:0]           year;
    logic [3:0]            month;
    logic [4:0]            day;
    logic [4:0]            hour;
    logic [5:0]            minute;
    logic [5:0]            second;

    png_time_chunk_scanner DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .year      (year),
        .month     (month),
        .day       (day),
        .hour      (hour),
        .minute    (minute),
        .second    (second)
    );

    // scanner model state
    phase_t      walk_phase = PH_SIG;
    logic [31:0] walk_count = '0;
    logic [31:0] chunk_len  = '0;
    logic [31:0] chunk_tag  = '0;
    logic [55:0] date_shift = '0;
    logic [55:0] date_kept  = '0;
    logic        have_time  = 1'b0;
    logic        sig_good   = 1'b0;
    logic [15:0] year_lo    = MIN_YEAR_RESET;
    logic [15:0] year_hi    = MAX_YEAR_RESET;

    tcs_result_t pending_reports[$];
    logic [7:0]  file_bytes[$];
    probe_row_t  probe_rows[21];

    int  mismatches     = 0;
    int  requests_sent  = 0;
    int  files_sent     = 0;
    int  windows_used   = 1;
    int  seen_bad_sig   = 0;
    int  seen_no_time   = 0;
    int  seen_found     = 0;
    bit  steady_sender  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("%0t: timeout, %0d reports still pending", $time, pending_reports.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bit date_in_range(input logic [55:0] d);
        return d[55:40] >= year_lo && d[55:40] <= year_hi &&
               d[39:32] >= 8'd1 && d[39:32] <= MONTH_MAX &&
               d[31:24] >= 8'd1 && d[31:24] <= DAY_MAX &&
               d[23:16] <= HOUR_MAX && d[15:8] <= MINUTE_MAX && d[7:0] <= SECOND_MAX;
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic lst,
                             output bit has_report, output tcs_result_t report);
        logic [55:0] shown;
        has_report = 1'b0;
        report = NO_REPORT;
        case (walk_phase)
            PH_SIG:
            begin
                if (b != PNG_MAGIC[63 - 8 * walk_count[2:0] -: 8])
                    walk_phase = PH_DONE;
                else if (walk_count == 32'd7)
                begin
                    sig_good = 1'b1;
                    walk_count = '0;
                    walk_phase = PH_LEN;
                end
                else
                    walk_count++;
            end
            PH_LEN:
            begin
                chunk_len = {chunk_len[23:0], b};
                walk_count++;
                if (walk_count == 32'd4)
                begin
                    walk_count = '0;
                    walk_phase = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                chunk_tag = {chunk_tag[23:0], b};
                walk_count++;
                if (walk_count == 32'd4)
                begin
                    walk_count = '0;
                    date_shift = '0;
                    if (chunk_tag == TYPE_IEND)
                        walk_phase = PH_DONE;
                    else
                        walk_phase = (chunk_len == '0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (chunk_tag == TYPE_TIME && chunk_len == TIME_LENGTH)
                    date_shift = {date_shift[47:0], b};
                walk_count++;
                if (walk_count == chunk_len)
                begin
                    walk_count = '0;
                    walk_phase = PH_CRC;
                end
            end
            PH_CRC:
            begin
                walk_count++;
                if (walk_count == 32'd4)
                begin
                    if (chunk_tag == TYPE_TIME && chunk_len == TIME_LENGTH &&
                        date_in_range(date_shift))
                    begin
                        date_kept = date_shift;
                        have_time = 1'b1;
                    end
                    walk_count = '0;
                    chunk_len = '0;
                    chunk_tag = '0;
                    walk_phase = PH_LEN;
                end
            end
            default:
            begin
            end
        endcase

        if (lst)
        begin
            shown = (sig_good && have_time) ? date_kept : '0;
            has_report = 1'b1;
            report.status = !sig_good ? STATUS_BAD_SIG :
                            (have_time ? STATUS_FOUND : STATUS_NO_TIME);
            report.year   = shown[55:40];
            report.month  = shown[35:32];
            report.day    = shown[28:24];
            report.hour   = shown[20:16];
            report.minute = shown[13:8];
            report.second = shown[5:0];
            walk_phase = PH_SIG;
            walk_count = '0;
            chunk_len  = '0;
            chunk_tag  = '0;
            date_shift = '0;
            date_kept  = '0;
            have_time  = 1'b0;
            sig_good   = 1'b0;
        end
    endtask

    task automatic compare_field(input string label, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic send_request(input logic [7:0] b, input logic lst, input bit pinned,
                                input tcs_result_t pinned_report);
        int          gap;
        bit          has_report;
        tcs_result_t report;
        gap = steady_sender ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do @(posedge clk); while (in_ready !== 1'b1);
        scan_byte(b, lst, has_report, report);
        if (has_report)
            pending_reports.push_back(pinned ? pinned_report : report);
        requests_sent++;
    endtask

    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                                input logic [15:0] wdata, output logic [15:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= {{(CFG_DATA_W - 16){1'b0}}, wdata};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata[15:0];
    endtask

    task automatic program_year_window(input bit do_write, input logic [15:0] lo,
                                       input logic [15:0] hi);
        logic [15:0] readback;
        if (do_write)
        begin
            apb_transfer(1'b1, MIN_YEAR_ADDR, lo, readback);
            year_lo = lo;
            apb_transfer(1'b1, MAX_YEAR_ADDR, hi, readback);
            year_hi = hi;
            windows_used++;
        end
        apb_transfer(1'b0, MIN_YEAR_ADDR, '0, readback);
        compare_field("min_year readback", year_lo, readback);
        apb_transfer(1'b0, MAX_YEAR_ADDR, '0, readback);
        compare_field("max_year readback", year_hi, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(w[8 * i +: 8]);
    endtask

    task automatic push_signature(input int spoil);
        logic [7:0] b;
        for (int i = 0; i < 8; i++)
        begin
            b = PNG_MAGIC[63 - 8 * i -: 8];
            if (i == spoil)
                b = b ^ 8'($urandom_range(1, 255));
            file_bytes.push_back(b);
        end
    endtask

    function automatic logic [7:0] date_part(input int lo, input int hi);
        case ($urandom_range(0, 11))
            0: return 8'(lo);
            1: return 8'(hi);
            2: return 8'(hi + 1);
            3: return (lo > 0) ? 8'(lo - 1) : 8'($urandom_range(hi + 1, 255));
            default: return 8'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic push_plain_chunk(input int len, input logic [31:0] tag);
        push_word(32'(len));
        push_word(tag);
        repeat (len) file_bytes.push_back(8'($urandom));
        push_word($urandom);
    endtask

    task automatic push_time_chunk();
        logic [15:0] yr;
        case ($urandom_range(0, 9))
            0: yr = year_lo;
            1: yr = year_hi;
            2: yr = year_lo - 16'd1;
            3: yr = year_hi + 16'd1;
            4: yr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: yr = (year_lo <= year_hi) ? 16'($urandom_range(year_lo, year_hi))
                                               : 16'($urandom);
        endcase
        push_word(TIME_LENGTH);
        push_word(TYPE_TIME);
        file_bytes.push_back(yr[15:8]);
        file_bytes.push_back(yr[7:0]);
        file_bytes.push_back(date_part(1, MONTH_MAX));
        file_bytes.push_back(date_part(1, DAY_MAX));
        file_bytes.push_back(date_part(0, HOUR_MAX));
        file_bytes.push_back(date_part(0, MINUTE_MAX));
        file_bytes.push_back(date_part(0, SECOND_MAX));
        push_word($urandom);
    endtask

    task automatic build_file();
        int kind;
        int pick;
        int len;
        int keep;
        file_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind < 8)
        begin
            push_signature(-1);
            repeat ($urandom_range(0, 4))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    push_time_chunk();
                else if (pick == 4)
                begin
                    do len = $urandom_range(0, 10); while (len == TIME_LENGTH);
                    push_plain_chunk(len, TYPE_TIME);
                end
                else
                    push_plain_chunk($urandom_range(0, 12), $urandom);
            end
            case ($urandom_range(0, 5))
                0:
                begin
                    push_plain_chunk($urandom_range(0, 1) ? 0 : $urandom_range(1, 4), TYPE_IEND);
                    if ($urandom_range(0, 1))
                        push_time_chunk();
                end
                1:
                begin
                    push_word($urandom);
                    push_word($urandom_range(0, 1) ? TYPE_TIME : $urandom);
                    repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
                end
                default:
                begin
                end
            endcase
            if ($urandom_range(0, 4) == 0)
            begin
                keep = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > keep)
                    void'(file_bytes.pop_back());
            end
        end
        else if (kind == 8)
        begin
            push_signature($urandom_range(0, 7));
            push_time_chunk();
        end
        else
        begin
            repeat ($urandom_range(1, 16)) file_bytes.push_back(8'($urandom));
        end
    endtask

    initial
    begin : drain_reports
        bit          calm;
        int          stall;
        tcs_result_t want;
        calm = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            case (status)
                STATUS_BAD_SIG: seen_bad_sig++;
                STATUS_NO_TIME: seen_no_time++;
                default:        seen_found++;
            endcase
            if (pending_reports.size() == 0)
            begin
                $display("%0t: report with nothing pending, status %0d year %0d", $time,
                         status, year);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("status", want.status, status);
                compare_field("year",   want.year,   year);
                compare_field("month",  want.month,  month);
                compare_field("day",    want.day,    day);
                compare_field("hour",   want.hour,   hour);
                compare_field("minute", want.minute, minute);
                compare_field("second", want.second, second);
            end
        end
    end

    initial
    begin : run_files
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] a;
        logic [15:0] b;
        int          win_start;
        int          win_files;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;

        probe_rows = '{
            {8'h00, 1'b1, 1'b1, NO_SIGNATURE},
            {8'h89, 1'b0, 1'b0, NO_REPORT},
            {8'h50, 1'b0, 1'b0, NO_REPORT},
            {8'hFF, 1'b1, 1'b1, NO_SIGNATURE},
            {8'h89, 1'b0, 1'b0, NO_REPORT},
            {8'h50, 1'b0, 1'b0, NO_REPORT},
            {8'h4E, 1'b0, 1'b0, NO_REPORT},
            {8'h47, 1'b0, 1'b0, NO_REPORT},
            {8'h0D, 1'b0, 1'b0, NO_REPORT},
            {8'h0A, 1'b0, 1'b0, NO_REPORT},
            {8'h1A, 1'b0, 1'b0, NO_REPORT},
            {8'h0A, 1'b0, 1'b0, NO_REPORT},
            {8'h00, 1'b0, 1'b0, NO_REPORT},
            {8'h00, 1'b0, 1'b0, NO_REPORT},
            {8'h00, 1'b0, 1'b0, NO_REPORT},
            {8'h00, 1'b0, 1'b0, NO_REPORT},
            {8'h49, 1'b0, 1'b0, NO_REPORT},
            {8'h45, 1'b0, 1'b0, NO_REPORT},
            {8'h4E, 1'b0, 1'b0, NO_REPORT},
            {8'h44, 1'b1, 1'b1, NO_TIME_FOUND},
            {8'hFF, 1'b1, 1'b1, NO_SIGNATURE}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_year_window(1'b0, '0, '0);

        foreach (probe_rows[i])
            send_request(probe_rows[i].b, probe_rows[i].lst, probe_rows[i].fixed,
                         probe_rows[i].want);
        files_sent += 4;
        wait_drained();

        for (int w = 0; w < WINDOW_COUNT; w++)
        begin
            lo = year_lo;
            hi = year_hi;
            case (w)
                1: begin lo = 16'd0;     hi = 16'd65535; end
                2: begin lo = 16'd0;     hi = 16'd0;     end
                3: begin lo = 16'd65535; hi = 16'd65535; end
                4: begin lo = 16'd2001;  hi = 16'd2000;  end
                5:
                begin
                    a = $urandom;
                    b = $urandom;
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                end
                6: begin lo = MIN_YEAR_RESET; hi = MAX_YEAR_RESET; end
                default:
                begin
                end
            endcase
            if (w > 0)
                program_year_window(1'b1, lo, hi);

            win_start = requests_sent;
            win_files = 0;
            while (requests_sent - win_start < BYTES_PER_WIN || win_files < FILES_PER_WIN)
            begin
                steady_sender = ($urandom_range(0, 3) == 0);
                build_file();
                foreach (file_bytes[i])
                    send_request(file_bytes[i], i == file_bytes.size() - 1, 1'b0, NO_REPORT);
                win_files++;
                files_sent++;
                // now and then, hold off until the scanner has emptied
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        $display("Scanned %0d files in %0d byte requests under %0d year windows.",
                 files_sent, requests_sent, windows_used);
        $display("Reports seen: %0d bad signature, %0d without time, %0d with time.",
                 seen_bad_sig, seen_no_time, seen_found);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/png_tcs_pkg.sv
hw/rtl/png_tcs_cfg.sv
hw/rtl/png_tcs_walker.sv
hw/rtl/png_time_chunk_scanner.sv
tb/sv/tb_png_time_chunk_scanner.sv
